// ===== rtl/ufcr_pkg.sv =====
// Package for the USB frame clock reference block.
// Holds widths, register indexes and the shared configuration and result types.
// No dependencies; every other file depends on it.
package ufcr_pkg;

    // Poll and result field widths
    localparam int FRAME_W      = 11;
    localparam int FRAME_BITS   = 11;
    localparam int TIME_W       = 32;
    localparam int COUNT_W      = 32;
    localparam int ELAPSED_W    = 64;
    localparam int STILL_W      = 16;

    // Configuration port
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_STILL_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT   = CFG_IDX_W'(1);

    localparam logic [STILL_W-1:0] STILL_LIMIT_RST = STILL_W'(5000);
    localparam logic [TIME_W-1:0]  GAP_LIMIT_RST   = TIME_W'(1500000);

    typedef struct packed {
        logic [STILL_W-1:0] still_limit;
        logic [TIME_W-1:0]  gap_limit_us;
    } cfg_t;

    typedef struct packed {
        logic                 reference_valid;
        logic [COUNT_W-1:0]   edge_frames;
        logic [ELAPSED_W-1:0] edge_elapsed_us;
        logic [COUNT_W-1:0]   ambiguous_count;
        logic [COUNT_W-1:0]   restart_count;
    } result_t;

endpackage

// ===== rtl/ufcr_if.sv =====
// Handshake interfaces for the USB frame clock reference block.
// Poll, result and configuration channels; depends on ufcr_pkg.

interface ufcr_poll_if;
    logic                          valid;
    logic                          ready;
    logic [ufcr_pkg::FRAME_W-1:0]  frame_number;
    logic [ufcr_pkg::TIME_W-1:0]   now_us;

    modport source (output valid, output frame_number, output now_us, input ready);
    modport sink   (input valid, input frame_number, input now_us, output ready);
endinterface

interface ufcr_result_if;
    logic                            valid;
    logic                            ready;
    logic                            reference_valid;
    logic [ufcr_pkg::COUNT_W-1:0]    edge_frames;
    logic [ufcr_pkg::ELAPSED_W-1:0]  edge_elapsed_us;
    logic [ufcr_pkg::COUNT_W-1:0]    ambiguous_count;
    logic [ufcr_pkg::COUNT_W-1:0]    restart_count;

    modport source (output valid, output reference_valid, output edge_frames,
                    output edge_elapsed_us, output ambiguous_count,
                    output restart_count, input ready);
    modport sink   (input valid, input reference_valid, input edge_frames,
                    input edge_elapsed_us, input ambiguous_count,
                    input restart_count, output ready);
endinterface

interface ufcr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ufcr_pkg::CFG_IDX_W-1:0]   index;
    logic [ufcr_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ufcr_cfg_regs.sv =====
// Configuration registers: still limit and gap limit.
// Depends on ufcr_pkg and ufcr_cfg_if.
module ufcr_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    ufcr_cfg_if.sink         cfg,
    output ufcr_pkg::cfg_t   cfg_out
);
    import ufcr_pkg::*;

    logic [STILL_W-1:0] still_limit_reg;
    logic [TIME_W-1:0]  gap_limit_reg;
    logic               wr_en;

    // Writes always accepted; unknown indexes are dropped
    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            still_limit_reg <= STILL_LIMIT_RST;
            gap_limit_reg   <= GAP_LIMIT_RST;
        end
        else if (wr_en)
        begin
            case (cfg.index)
                REG_STILL_LIMIT: still_limit_reg <= cfg.data[STILL_W-1:0];
                REG_GAP_LIMIT:   gap_limit_reg   <= cfg.data[TIME_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg_out.still_limit  = still_limit_reg;
    assign cfg_out.gap_limit_us = gap_limit_reg;

endmodule

// ===== rtl/ufcr_core.sv =====
// Span tracking state and its one-poll update.
// Depends on ufcr_pkg; fed by the top level's input register.
module ufcr_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_en,
    input  logic [ufcr_pkg::FRAME_W-1:0]    frame_number,
    input  logic [ufcr_pkg::TIME_W-1:0]     now_us,
    input  ufcr_pkg::cfg_t                  cfg,
    output ufcr_pkg::result_t               result
);
    import ufcr_pkg::*;

    logic                  span_started_reg,    span_started_next;
    logic [FRAME_BITS-1:0] last_frame_reg,      last_frame_next;
    logic [TIME_W-1:0]     last_time_reg,       last_time_next;
    logic [STILL_W-1:0]    still_polls_reg,     still_polls_next;
    logic [COUNT_W-1:0]    frames_total_reg,    frames_total_next;
    logic [ELAPSED_W-1:0]  elapsed_total_reg,   elapsed_total_next;
    logic [COUNT_W-1:0]    latched_frames_reg,  latched_frames_next;
    logic [ELAPSED_W-1:0]  latched_elapsed_reg, latched_elapsed_next;
    logic [COUNT_W-1:0]    gap_events_reg,      gap_events_next;
    logic [COUNT_W-1:0]    span_restarts_reg,   span_restarts_next;

    logic [FRAME_BITS-1:0] cur;
    logic [FRAME_BITS-1:0] step;
    logic [TIME_W-1:0]     delta;
    logic [STILL_W-1:0]    still_inc;
    logic                  same_frame;

    assign cur        = frame_number[FRAME_BITS-1:0];
    assign same_frame = (cur == last_frame_reg);
    assign delta      = now_us - last_time_reg;
    assign step       = cur - last_frame_reg;
    assign still_inc  = still_polls_reg + STILL_W'(1);

    // Next state for one poll
    always_comb
    begin
        span_started_next    = span_started_reg;
        last_frame_next      = last_frame_reg;
        last_time_next       = last_time_reg;
        still_polls_next     = still_polls_reg;
        frames_total_next    = frames_total_reg;
        elapsed_total_next   = elapsed_total_reg;
        latched_frames_next  = latched_frames_reg;
        latched_elapsed_next = latched_elapsed_reg;
        gap_events_next      = gap_events_reg;
        span_restarts_next   = span_restarts_reg;

        if (span_started_reg && same_frame)
        begin
            // Frame number stuck: count toward the still limit
            still_polls_next = still_inc;
            if (still_inc >= cfg.still_limit)
            begin
                still_polls_next     = '0;
                span_started_next    = 1'b0;
                frames_total_next    = '0;
                elapsed_total_next   = '0;
                latched_frames_next  = '0;
                latched_elapsed_next = '0;
                span_restarts_next   = span_restarts_reg + COUNT_W'(1);
            end
        end
        else
        begin
            still_polls_next = '0;
            last_frame_next  = cur;
            last_time_next   = now_us;
            if (!span_started_reg)
            begin
                // Start once the frame moves from a nonzero value
                if (!same_frame && (last_frame_reg != '0))
                    span_started_next = 1'b1;
            end
            else if (delta > cfg.gap_limit_us)
            begin
                // Over-long gap: new epoch, span stays up
                gap_events_next      = gap_events_reg + COUNT_W'(1);
                span_restarts_next   = span_restarts_reg + COUNT_W'(1);
                frames_total_next    = '0;
                elapsed_total_next   = '0;
                latched_frames_next  = '0;
                latched_elapsed_next = '0;
            end
            else
            begin
                elapsed_total_next = elapsed_total_reg + ELAPSED_W'(delta);
                frames_total_next  = frames_total_reg + COUNT_W'(step);
                if (step == FRAME_BITS'(1))
                begin
                    latched_frames_next  = frames_total_next;
                    latched_elapsed_next = elapsed_total_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_started_reg    <= 1'b0;
            last_frame_reg      <= '0;
            last_time_reg       <= '0;
            still_polls_reg     <= '0;
            frames_total_reg    <= '0;
            elapsed_total_reg   <= '0;
            latched_frames_reg  <= '0;
            latched_elapsed_reg <= '0;
            gap_events_reg      <= '0;
            span_restarts_reg   <= '0;
        end
        else if (step_en)
        begin
            span_started_reg    <= span_started_next;
            last_frame_reg      <= last_frame_next;
            last_time_reg       <= last_time_next;
            still_polls_reg     <= still_polls_next;
            frames_total_reg    <= frames_total_next;
            elapsed_total_reg   <= elapsed_total_next;
            latched_frames_reg  <= latched_frames_next;
            latched_elapsed_reg <= latched_elapsed_next;
            gap_events_reg      <= gap_events_next;
            span_restarts_reg   <= span_restarts_next;
        end
    end

    // Result after this poll's update
    assign result.reference_valid = span_started_next;
    assign result.edge_frames     = span_started_next ? latched_frames_next : '0;
    assign result.edge_elapsed_us = span_started_next ? latched_elapsed_next : '0;
    assign result.ambiguous_count = gap_events_next;
    assign result.restart_count   = span_restarts_next;

endmodule

// ===== rtl/usb_frame_clock_reference.sv =====
// Top level of the USB frame clock reference block.
// Depends on ufcr_pkg, ufcr_if, ufcr_cfg_regs and ufcr_core.

// Each accepted poll (frame number plus microsecond timestamp) yields exactly
// one result item carrying span validity, the frame count and elapsed time
// latched at the last single-frame step, and the ambiguous-gap and restart
// counters. A poll is taken into an input register, updated combinationally
// against the span state, and its result lands in an output register, so the
// block sustains one poll per clock while the sink keeps up; result valid rises
// once the poll moves from the input to the output register. The output register
// stalls the pipe only while a result is held by the sink. Configuration writes
// are taken every cycle and must only be issued while no poll is in flight.
module usb_frame_clock_reference (
    input  logic           clk,
    input  logic           rst_n,
    ufcr_poll_if.sink      poll,
    ufcr_result_if.source  result,
    ufcr_cfg_if.sink       cfg
);
    import ufcr_pkg::*;

    logic               in_valid_reg,  in_valid_next;
    logic [FRAME_W-1:0] in_frame_reg;
    logic [TIME_W-1:0]  in_now_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg;
    result_t            core_result;
    cfg_t               cfg_val;
    logic               poll_take;
    logic               advance;

    ufcr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    ufcr_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (advance),
        .frame_number (in_frame_reg),
        .now_us       (in_now_reg),
        .cfg          (cfg_val),
        .result       (core_result)
    );

    // Flow control
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign poll.ready = !in_valid_reg || advance;
    assign poll_take  = poll.valid && poll.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (poll_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (poll_take)
        begin
            in_frame_reg <= poll.frame_number;
            in_now_reg   <= poll.now_us;
        end
        if (advance)
            out_data_reg <= core_result;
    end

    assign result.valid           = out_valid_reg;
    assign result.reference_valid = out_data_reg.reference_valid;
    assign result.edge_frames     = out_data_reg.edge_frames;
    assign result.edge_elapsed_us = out_data_reg.edge_elapsed_us;
    assign result.ambiguous_count = out_data_reg.ambiguous_count;
    assign result.restart_count   = out_data_reg.restart_count;

    // An empty input register never blocks a poll
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> poll.ready)
        else $error("poll stalled with empty input register");

    // Each processed poll shows up as a result next cycle
    a_advance_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed poll lost before the output register");

    // Outside a span the latched pair reads as zero
    a_no_span_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.reference_valid) |->
            (result.edge_frames == '0 && result.edge_elapsed_us == '0))
        else $error("latched values shown without a span");

    // A gap event always counts a restart in the same poll
    a_gap_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && core_result.ambiguous_count != u_core.gap_events_reg)
            |-> (core_result.restart_count == u_core.span_restarts_reg + COUNT_W'(1)))
        else $error("gap counted without a restart");

endmodule
